// ----- sv/rgt_pkg.sv -----
// Shared types, codes and the divisor-order table for the rectangle grid tiler.
`timescale 1ns / 1ps

package rgt_pkg;

    // Largest tile count served; the index and count widths are sized for it
    localparam int MAX_TILES = 64;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOREG = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_CUT_X = 2'd1;
    localparam logic [1:0] CFG_CUT_Y = 2'd2;

    // Split modes (code three behaves as best)
    localparam logic [1:0] MODE_BEST = 2'd0;
    localparam logic [1:0] MODE_REG  = 2'd1;
    localparam logic [1:0] MODE_IRR  = 2'd2;

    localparam int DIV_SLOTS = 16;   // most divisors of any 7-bit count
    localparam int NUM_CODES = 128;  // every 7-bit tile count

    // Divisor list of one tile count: divisors in search order and cofactors
    typedef struct packed {
        logic [4:0]                 cnt;
        logic [DIV_SLOTS-1:0][6:0]  d;
        logic [DIV_SLOTS-1:0][6:0]  q;
    } t_div_row;

    typedef t_div_row [NUM_CODES-1:0] t_div_tab;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic err_bad;
        logic err_noreg;
        logic div_go;
        logic div_h;
        logic pq;
        logic mul;
        logic upd;
        logic next;
        logic to_irr;
        logic pick;
        logic setup;
        logic row;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic idx_last;
        logic sel_ok;
        logic col_last;
        logic tile_last;
        logic irr;
        logic mode_reg;
        logic mode_irr;
    } t_stat;

    // True when a divides b (small values only)
    function automatic bit f_divides(input int a, input int b);
        bit res;
        res = 1'b0;
        for (int q = 0; q < NUM_CODES; q++) begin
            if (a * q == b) res = 1'b1;
        end
        return res;
    endfunction

    // Exact quotient b / a found by search (small values only)
    function automatic int f_quot(input int a, input int b);
        int res;
        res = 0;
        for (int q = 0; q < NUM_CODES; q++) begin
            if (a * q == b) res = q;
        end
        return res;
    endfunction

    // Divisors of n, first prime's exponent slowest, last prime's fastest
    function automatic t_div_row f_div_row(input int n);
        int pr [3];
        int ex [3];
        int cn [3];
        int np;
        int m;
        int v;
        int tot;
        bit carry;
        t_div_row row;
        row = '0;
        np  = 0;
        m   = n;
        for (int i = 0; i < 3; i++) begin
            pr[i] = 1;
            ex[i] = 0;
            cn[i] = 0;
        end
        for (int p = 2; p < NUM_CODES; p++) begin
            if (p <= m && np < 3 && f_divides(p, m)) begin
                pr[np] = p;
                for (int k = 0; k < 7; k++) begin
                    if (f_divides(p, m)) begin
                        m = f_quot(p, m);
                        ex[np] = ex[np] + 1;
                    end
                end
                np = np + 1;
            end
        end
        tot = 1;
        for (int i = 0; i < 3; i++) begin
            if (i < np) tot = tot * (ex[i] + 1);
        end
        for (int j = 0; j < DIV_SLOTS; j++) begin
            if (j < tot) begin
                v = 1;
                for (int i = 0; i < 3; i++) begin
                    for (int k = 0; k < 7; k++) begin
                        if (i < np && k < cn[i]) v = v * pr[i];
                    end
                end
                row.d[j] = 7'(v);
                row.q[j] = 7'(f_quot(v, n));
                carry = 1'b1;
                for (int i = 2; i >= 0; i--) begin
                    if (carry && i < np) begin
                        cn[i] = cn[i] + 1;
                        if (cn[i] > ex[i]) cn[i] = 0;
                        else carry = 1'b0;
                    end
                end
            end
        end
        row.cnt = 5'(tot);
        return row;
    endfunction

    function automatic t_div_tab f_build_tab();
        t_div_tab tab;
        for (int n = 0; n < NUM_CODES; n++) begin
            tab[n] = f_div_row(n);
        end
        return tab;
    endfunction

    localparam t_div_tab DIV_TAB = f_build_tab();

endpackage

// ----- sv/rgt_div.sv -----
// Iterative restoring divider, 16-bit dividend by 7-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module rgt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [15:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_done,
    output logic [15:0] o_quo,
    output logic [6:0]  o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_quo;
    logic [6:0]  r_rem;
    logic [6:0]  r_dvs;
    logic [7:0]  w_trial;
    logic        w_ge;
    logic [7:0]  w_diff;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[15]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[6:0] : w_trial[6:0];
            r_quo <= {r_quo[14:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- sv/rgt_dpath.sv -----
// Tiler datapath: configuration, candidate scoring, cut generation and result register.
`timescale 1ns / 1ps

module rgt_dpath (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic [15:0]  i_area_width,
    input  logic [15:0]  i_area_height,
    input  logic [6:0]   i_num_tiles,
    input  rgt_pkg::t_cmd  i_cmd,
    output rgt_pkg::t_stat o_stat,
    output logic         o_valid,
    output logic [5:0]   o_tile_index,
    output logic [15:0]  o_x_min,
    output logic [15:0]  o_x_max,
    output logic [15:0]  o_y_min,
    output logic [15:0]  o_y_max,
    output logic [1:0]   o_status,
    output logic         o_last
);
    import rgt_pkg::*;

    logic [1:0]  r_mode;
    logic [15:0] r_cut_x, r_cut_y;
    logic [15:0] r_w, r_h;
    logic [6:0]  r_n;
    logic [3:0]  r_idx, r_bidx;
    logic        r_found, r_irr, r_dsel;
    logic [15:0] r_qw, r_qh;
    logic [6:0]  r_rw, r_rh;
    logic [22:0] r_p, r_q;
    logic [45:0] r_l, r_r;
    logic [22:0] r_bmn, r_bmx;
    logic [22:0] r_thx, r_thy, r_wtx;
    logic [15:0] r_x0, r_xq, r_y0, r_y1, r_yq;
    logic [6:0]  r_xr, r_yr;
    logic [22:0] r_xl, r_yl;
    logic [6:0]  r_k, r_c;
    logic        r_o_valid;
    logic [5:0]  r_o_idx;
    logic [15:0] r_o_x0, r_o_x1, r_o_y0, r_o_y1;
    logic [1:0]  r_o_status;
    logic        r_o_last;

    t_div_row    w_row;
    logic [6:0]  w_f1, w_f2;
    logic        w_div_done;
    logic [15:0] w_quo;
    logic [6:0]  w_rem;
    logic [22:0] w_mn, w_mx, w_dev;
    logic        w_ok, w_better;
    logic [22:0] w_thx_raw, w_thy_raw;
    logic [7:0]  w_xr_sum, w_yr_sum;
    logic        w_xc, w_yc;
    logic [6:0]  w_xr_nxt, w_yr_nxt;
    logic [15:0] w_xq_nxt, w_yq_nxt;
    logic [22:0] w_xl_nxt, w_yl_nxt;
    logic [15:0] w_x1, w_y1;
    logic        w_col_last, w_tile_last;

    // Candidate pair from the divisor table
    assign w_row = DIV_TAB[r_n];
    assign w_f1  = w_row.d[r_idx];
    assign w_f2  = w_row.q[r_idx];

    rgt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (i_cmd.div_h ? r_h : r_w),
        .i_divisor  (i_cmd.div_h ? w_f2 : w_f1),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Score the candidate: squareness for regular, aspect deviation for irregular
    assign w_mn  = (r_p < r_q) ? r_p : r_q;
    assign w_mx  = (r_p < r_q) ? r_q : r_p;
    assign w_dev = (r_p > r_q) ? (r_p - r_q) : (r_q - r_p);
    assign w_ok  = (r_rw == 7'd0) && (r_rh == 7'd0);
    assign w_better = r_irr ? (!r_found || (r_l < r_r))
                            : (w_ok && (!r_found || (r_l >= r_r)));

    // Snap thresholds
    assign w_thx_raw = {7'd0, r_cut_x} * {16'd0, w_f1};
    assign w_thy_raw = {7'd0, r_cut_y} * {16'd0, w_f2};

    // Next column cut: quotient and remainder advance by w/tx
    assign w_xr_sum = {1'b0, r_xr} + {1'b0, r_rw};
    assign w_xc     = w_xr_sum >= {1'b0, w_f1};
    assign w_xr_nxt = w_xc ? 7'(w_xr_sum - {1'b0, w_f1}) : w_xr_sum[6:0];
    assign w_xq_nxt = r_xq + r_qw + {15'd0, w_xc};
    assign w_xl_nxt = r_xl - {7'd0, r_w};
    assign w_x1     = (w_xl_nxt < r_thx) ? r_w : w_xq_nxt;

    // Next row cut
    assign w_yr_sum = {1'b0, r_yr} + {1'b0, r_rh};
    assign w_yc     = w_yr_sum >= {1'b0, w_f2};
    assign w_yr_nxt = w_yc ? 7'(w_yr_sum - {1'b0, w_f2}) : w_yr_sum[6:0];
    assign w_yq_nxt = r_yq + r_qh + {15'd0, w_yc};
    assign w_yl_nxt = r_yl - {7'd0, r_h};
    assign w_y1     = (w_yl_nxt < r_thy) ? r_h : w_yq_nxt;

    assign w_col_last  = (r_c + 7'd1) == w_f1;
    assign w_tile_last = (r_k + 7'd1) == r_n;

    // Configuration registers and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BEST;
            r_cut_x   <= 16'd1;
            r_cut_y   <= 16'd1;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit || i_cmd.err_bad || i_cmd.err_noreg;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    CFG_CUT_X: r_cut_x <= i_cfg_data;
                    CFG_CUT_Y: r_cut_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Search and emission registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w     <= i_area_width;
            r_h     <= i_area_height;
            r_n     <= i_num_tiles;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_irr   <= (r_mode == MODE_IRR);
        end
        if (i_cmd.div_go) r_dsel <= i_cmd.div_h;
        if (w_div_done) begin
            if (r_dsel) begin
                r_qh <= w_quo;
                r_rh <= w_rem;
            end else begin
                r_qw <= w_quo;
                r_rw <= w_rem;
            end
        end
        if (i_cmd.pq) begin
            r_p <= {7'd0, r_w} * {16'd0, w_f2};
            r_q <= {7'd0, r_h} * {16'd0, w_f1};
            // irregular cuts ignore remainders during the search
            if (r_irr) begin
                r_rw <= '0;
                r_rh <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_l <= {23'd0, (r_irr ? w_dev : w_mn)} * {23'd0, r_bmx};
            r_r <= {23'd0, r_bmn} * {23'd0, (r_irr ? {16'd0, w_f1} : w_mx)};
        end
        if (i_cmd.upd && w_better) begin
            r_found <= 1'b1;
            r_bidx  <= r_idx;
            r_bmn   <= r_irr ? w_dev : w_mn;
            r_bmx   <= r_irr ? {16'd0, w_f1} : w_mx;
        end
        if (i_cmd.next) r_idx <= r_idx + 4'd1;
        if (i_cmd.to_irr) begin
            r_irr   <= 1'b1;
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.pick) r_idx <= w_better ? r_idx : r_bidx;
        if (i_cmd.setup) begin
            r_thx <= r_irr ? (({7'd0, r_w} < w_thx_raw) ? {16'd0, w_f1} : w_thx_raw) : '0;
            r_thy <= r_irr ? (({7'd0, r_h} < w_thy_raw) ? {16'd0, w_f2} : w_thy_raw) : '0;
            r_wtx <= {7'd0, r_w} * {16'd0, w_f1};
            r_yl  <= {7'd0, r_h} * {16'd0, w_f2};
            r_y0  <= '0;
            r_yq  <= '0;
            r_yr  <= '0;
            r_k   <= '0;
            r_c   <= '0;
        end
        if (i_cmd.row) begin
            r_y1 <= w_y1;
            r_yq <= w_yq_nxt;
            r_yr <= w_yr_nxt;
            r_yl <= w_yl_nxt;
            r_x0 <= '0;
            r_xq <= '0;
            r_xr <= '0;
            r_xl <= r_wtx;
        end
        if (i_cmd.emit) begin
            r_o_idx    <= r_k[5:0];
            r_o_x0     <= r_x0;
            r_o_x1     <= w_x1;
            r_o_y0     <= r_y0;
            r_o_y1     <= r_y1;
            r_o_status <= STATUS_OK;
            r_o_last   <= w_tile_last;
            r_x0 <= w_x1;
            r_xq <= w_xq_nxt;
            r_xr <= w_xr_nxt;
            r_xl <= w_xl_nxt;
            r_k  <= r_k + 7'd1;
            if (w_col_last) begin
                r_c  <= '0;
                r_y0 <= r_y1;
            end else begin
                r_c <= r_c + 7'd1;
            end
        end
        if (i_cmd.err_bad || i_cmd.err_noreg) begin
            r_o_idx    <= '0;
            r_o_x0     <= '0;
            r_o_x1     <= '0;
            r_o_y0     <= '0;
            r_o_y1     <= '0;
            r_o_status <= i_cmd.err_bad ? STATUS_BAD : STATUS_NOREG;
            r_o_last   <= 1'b1;
        end
    end

    always_comb begin
        o_stat.div_done  = w_div_done;
        o_stat.idx_last  = ({1'b0, r_idx} + 5'd1) == w_row.cnt;
        o_stat.sel_ok    = r_found || w_better;
        o_stat.col_last  = w_col_last;
        o_stat.tile_last = w_tile_last;
        o_stat.irr       = r_irr;
        o_stat.mode_reg  = (r_mode == MODE_REG);
        o_stat.mode_irr  = (r_mode == MODE_IRR);
    end

    assign o_valid      = r_o_valid;
    assign o_tile_index = r_o_idx;
    assign o_x_min      = r_o_x0;
    assign o_x_max      = r_o_x1;
    assign o_y_min      = r_o_y0;
    assign o_y_max      = r_o_y1;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;
endmodule

// ----- sv/rgt_ctrl.sv -----
// Tiler controller: sequences the divisor search, cut setup and tile emission.
`timescale 1ns / 1ps

module rgt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_bad_n,
    input  rgt_pkg::t_stat i_stat,
    output rgt_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import rgt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RDW_GO = 4'd1;
    localparam logic [3:0] ST_RDW_WT = 4'd2;
    localparam logic [3:0] ST_RDH_GO = 4'd3;
    localparam logic [3:0] ST_RDH_WT = 4'd4;
    localparam logic [3:0] ST_PQ     = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_UPD    = 4'd7;
    localparam logic [3:0] ST_SDW_GO = 4'd8;
    localparam logic [3:0] ST_SDW_WT = 4'd9;
    localparam logic [3:0] ST_SDH_GO = 4'd10;
    localparam logic [3:0] ST_SDH_WT = 4'd11;
    localparam logic [3:0] ST_SETUP  = 4'd12;
    localparam logic [3:0] ST_ROW    = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_bad_n) begin
                        o_cmd.err_bad = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = i_stat.mode_irr ? ST_PQ : ST_RDW_GO;
                    end
                end
            end
            ST_RDW_GO: begin
                o_cmd.div_go = 1'b1;
                n_state = ST_RDW_WT;
            end
            ST_RDW_WT: if (i_stat.div_done) n_state = ST_RDH_GO;
            ST_RDH_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_h  = 1'b1;
                n_state = ST_RDH_WT;
            end
            ST_RDH_WT: if (i_stat.div_done) n_state = ST_PQ;
            ST_PQ: begin
                o_cmd.pq = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                if (!i_stat.idx_last) begin
                    o_cmd.next = 1'b1;
                    n_state = i_stat.irr ? ST_PQ : ST_RDW_GO;
                end else if (i_stat.sel_ok) begin
                    o_cmd.pick = 1'b1;
                    n_state = ST_SDW_GO;
                end else if (i_stat.mode_reg) begin
                    o_cmd.err_noreg = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.to_irr = 1'b1;
                    n_state = ST_PQ;
                end
            end
            ST_SDW_GO: begin
                o_cmd.div_go = 1'b1;
                n_state = ST_SDW_WT;
            end
            ST_SDW_WT: if (i_stat.div_done) n_state = ST_SDH_GO;
            ST_SDH_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_h  = 1'b1;
                n_state = ST_SDH_WT;
            end
            ST_SDH_WT: if (i_stat.div_done) n_state = ST_SETUP;
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                o_cmd.row = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.col_last) n_state = i_stat.tile_last ? ST_IDLE : ST_ROW;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

// ----- sv/rect_grid_tiler.sv -----
// Rectangle grid tiler: splits a W x H area into N tiles and streams their bounds.
//
// Start a request by holding i_start high while o_busy is low; width, height and
// tile count are transferred at that edge. Results come out one per cycle-wide
// o_valid strobe in row-major order, o_last marking the final one; the receiver
// cannot stall and must take each result in its cycle. A bad tile count (zero or
// above MAX_TILES) gives one error result the cycle after the transfer. Otherwise
// the block scans the divisors of N one at a time through a shared bit-serial
// divider: a regular candidate takes two divisions, a product, a cross-multiply
// and an update, an irregular candidate only the last three; then come two
// more divisions and the cut setup, then a row step per row and an emit step
// per tile. A best-mode request that finds no regular split rescans every
// candidate as irregular. o_busy drops in the cycle that shows the final result,
// so the next request can be transferred there. Configuration (split mode, two
// snap cutoffs) is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Synchronous active-low reset returns to idle with mode best and cutoffs one.
`timescale 1ns / 1ps

module rect_grid_tiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_area_width,
    input  logic [15:0] i_area_height,
    input  logic [6:0]  i_num_tiles,
    output logic        o_valid,
    output logic [5:0]  o_tile_index,
    output logic [15:0] o_x_min,
    output logic [15:0] o_x_max,
    output logic [15:0] o_y_min,
    output logic [15:0] o_y_max,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import rgt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_bad_n;

    // Reject counts outside one to MAX_TILES
    assign w_bad_n = (i_num_tiles == 7'd0) || (32'(i_num_tiles) > MAX_TILES);

    rgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_bad_n (w_bad_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    rgt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_area_width  (i_area_width),
        .i_area_height (i_area_height),
        .i_num_tiles   (i_num_tiles),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_tile_index  (o_tile_index),
        .o_x_min       (o_x_min),
        .o_x_max       (o_x_max),
        .o_y_min       (o_y_min),
        .o_y_max       (o_y_max),
        .o_status      (o_status),
        .o_last        (o_last)
    );
endmodule

// ----- sv/rgt_chk.sv -----
// Port-level checker for the tiler, bound to the top level.
`timescale 1ns / 1ps

module rgt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [6:0]  i_num_tiles,
    input logic        o_valid,
    input logic [5:0]  o_tile_index,
    input logic [15:0] o_x_min,
    input logic [15:0] o_x_max,
    input logic [15:0] o_y_min,
    input logic [15:0] o_y_max,
    input logic [1:0]  o_status,
    input logic        o_last
);
    import rgt_pkg::*;

    // The final transfer of a request leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy)
        else $error("busy after final result");

    // A result that is not final belongs to a request still running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("intermediate result while idle");

    // Error results are single, final and all zero
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |-> o_last && o_tile_index == 6'd0 &&
        o_x_min == 16'd0 && o_x_max == 16'd0 && o_y_min == 16'd0 && o_y_max == 16'd0)
        else $error("malformed error result");

    // A zero tile count is answered in the next cycle
    a_zero_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_num_tiles == 7'd0 |=>
        o_valid && o_status == STATUS_BAD && o_last)
        else $error("zero tile count not rejected");
endmodule

bind rect_grid_tiler rgt_chk u_rgt_chk (.*);

// ----- sim/tb_rect_grid_tiler.sv -----
// Self-checking testbench for the rectangle grid tiler: directed table, then random requests.
`timescale 1ns / 1ps

module tb_rect_grid_tiler;
    import rgt_pkg::*;

    typedef struct packed {
        logic [5:0]  idx;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
        logic [1:0]  st;
        logic        lst;
    } t_tile;

    typedef struct {
        logic [15:0] w;
        logic [15:0] h;
        logic [6:0]  n;
        bit          has_exp;
        t_tile       exp_tile;
    } t_req_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_area_width;
    logic [15:0] i_area_height;
    logic [6:0]  i_num_tiles;
    logic        o_valid;
    logic [5:0]  o_tile_index;
    logic [15:0] o_x_min;
    logic [15:0] o_x_max;
    logic [15:0] o_y_min;
    logic [15:0] o_y_max;
    logic [1:0]  o_status;
    logic        o_last;

    // Local copy of the configuration
    logic [1:0]  mdl_mode;
    logic [15:0] mdl_cut_x;
    logic [15:0] mdl_cut_y;

    t_tile tile_q[$];
    int    err_cnt;
    int    tile_cnt;
    int    req_cnt;

    rect_grid_tiler dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb_rect_grid_tiler failed");
        $finish;
    end

    // Append one expected tile to the queue
    task automatic queue_exp(input t_tile t);
        tile_q = {tile_q, t};
    endtask

    // Divisors of n, first prime's exponent slowest
    function automatic int tile_divisors(input int n, output int dv[64]);
        int pr[8], ex[8], cn[8];
        int np, m, cnt, v, i;
        np = 0;
        m = n;
        cnt = 0;
        for (int p = 2; p <= m; p++) begin
            if (m % p == 0) begin
                pr[np] = p;
                ex[np] = 0;
                cn[np] = 0;
                while (m % p == 0) begin
                    m = m / p;
                    ex[np]++;
                end
                np++;
            end
        end
        forever begin
            v = 1;
            for (i = 0; i < np; i++)
                for (int k = 0; k < cn[i]; k++) v = v * pr[i];
            dv[cnt++] = v;
            i = np - 1;
            while (i >= 0) begin
                cn[i]++;
                if (cn[i] <= ex[i]) break;
                cn[i] = 0;
                i--;
            end
            if (i < 0) break;
        end
        return cnt;
    endfunction

    function automatic longint cut_pos(input longint len, input longint parts,
                                       input longint k, input longint cut);
        longint v;
        v = (k * len) / parts;
        if (len * (parts - k) < cut * parts) v = len;
        return v;
    endfunction

    function automatic t_tile mk_tile(input int idx, input longint x0, input longint x1,
                                      input longint y0, input longint y1,
                                      input logic [1:0] st, input bit lst);
        t_tile t;
        t.idx = 6'(idx);
        t.x0 = 16'(x0);
        t.x1 = 16'(x1);
        t.y0 = 16'(y0);
        t.y1 = 16'(y1);
        t.st = st;
        t.lst = lst;
        return t;
    endfunction

    // Predict the full tile list of one request and queue it
    task automatic predict_tiles(input int w, input int h, input int n);
        int dv[64];
        int nd, best, tx, ty, k;
        longint bmn, bmx, p, q, mn, mx, bdev, b1, s, t, dev, cx, cy, y0, y1, x0, x1;
        if (n == 0 || n > MAX_TILES) begin
            queue_exp(mk_tile(0, 0, 0, 0, 0, STATUS_BAD, 1'b1));
            return;
        end
        if (n == 1) begin
            queue_exp(mk_tile(0, 0, w, 0, h, STATUS_OK, 1'b1));
            return;
        end
        nd = tile_divisors(n, dv);
        best = -1;
        if (mdl_mode != MODE_IRR) begin
            bmn = 0;
            bmx = 0;
            for (int i = 0; i < nd; i++) begin
                if (w % dv[i] == 0 && h % (n / dv[i]) == 0) begin
                    p = longint'(w) * (n / dv[i]);
                    q = longint'(h) * dv[i];
                    mn = p < q ? p : q;
                    mx = p < q ? q : p;
                    if (best < 0 || mn * bmx >= bmn * mx) begin
                        best = i;
                        bmn = mn;
                        bmx = mx;
                    end
                end
            end
            if (best >= 0) begin
                tx = dv[best];
                ty = n / tx;
                k = 0;
                for (int r = 0; r < ty; r++)
                    for (int c = 0; c < tx; c++) begin
                        queue_exp(mk_tile(k, c * (w / tx), (c + 1) * (w / tx),
                            r * (h / ty), (r + 1) * (h / ty), STATUS_OK, k + 1 == n));
                        k++;
                    end
                return;
            end
            if (mdl_mode == MODE_REG) begin
                queue_exp(mk_tile(0, 0, 0, 0, 0, STATUS_NOREG, 1'b1));
                return;
            end
        end
        best = -1;
        bdev = 0;
        b1 = 1;
        for (int i = 0; i < nd; i++) begin
            s = longint'(w) * (n / dv[i]);
            t = longint'(h) * dv[i];
            dev = s > t ? s - t : t - s;
            if (best < 0 || dev * b1 < bdev * dv[i]) begin
                best = i;
                bdev = dev;
                b1 = dv[i];
            end
        end
        tx = dv[best];
        ty = n / tx;
        cx = longint'(mdl_cut_x);
        cy = longint'(mdl_cut_y);
        if (w < cx * tx) cx = 1;
        if (h < cy * ty) cy = 1;
        k = 0;
        y0 = 0;
        for (int r = 0; r < ty; r++) begin
            y1 = cut_pos(h, ty, r + 1, cy);
            x0 = 0;
            for (int c = 0; c < tx; c++) begin
                x1 = cut_pos(w, tx, c + 1, cx);
                queue_exp(mk_tile(k, x0, x1, y0, y1, STATUS_OK, k + 1 == n));
                k++;
                x0 = x1;
            end
            y0 = y1;
        end
    endtask

    // Compare every strobed tile with the oldest expected one
    always @(posedge i_clk) begin
        t_tile got, want;
        if (i_rst_n && o_valid) begin
            got = {o_tile_index, o_x_min, o_x_max, o_y_min, o_y_max, o_status, o_last};
            tile_cnt++;
            if (tile_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected tile %h", got);
            end else begin
                want = tile_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tile mismatch: exp idx %0d x %0d..%0d y %0d..%0d st %0d l %0d / got idx %0d x %0d..%0d y %0d..%0d st %0d l %0d",
                            want.idx, want.x0, want.x1, want.y0, want.y1, want.st, want.lst,
                            got.idx, got.x0, got.x1, got.y0, got.y1, got.st, got.lst);
                end
            end
        end
    end

    task automatic wait_drain();
        while (tile_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  mdl_mode = val[1:0];
            CFG_CUT_X: mdl_cut_x = val;
            CFG_CUT_Y: mdl_cut_y = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [1:0] m, input logic [15:0] cx, input logic [15:0] cy);
        write_cfg(CFG_MODE, {14'd0, m});
        write_cfg(CFG_CUT_X, cx);
        write_cfg(CFG_CUT_Y, cy);
    endtask

    // Hold start until the transfer, then queue what it should produce
    task automatic send_req(input logic [15:0] w, input logic [15:0] h, input logic [6:0] n,
                            input bit has_exp, input t_tile exp_tile);
        i_area_width <= w;
        i_area_height <= h;
        i_num_tiles <= n;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (has_exp) queue_exp(exp_tile);
        else predict_tiles(int'(w), int'(h), int'(n));
        req_cnt++;
    endtask

    // Drop start after a transfer unless another one follows right away
    task automatic idle_gap(input int cyc);
        if (cyc > 0) begin
            i_start <= 1'b0;
            repeat (cyc) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rnd_side();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(1, 4));
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 64) * $urandom_range(1, 16));
            3: return 16'($urandom);
            4: return 16'($urandom_range(1, 200));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [6:0] rnd_count();
        case ($urandom_range(0, 9))
            0: return 7'($urandom_range(65, 127));
            1: return 7'd0;
            2: return 7'($urandom_range(32, 64));
            default: return 7'($urandom_range(1, 24));
        endcase
    endfunction

    t_req_row dir_tab[] = '{
        '{16'd100, 16'd100, 7'd0,   1'b1, '{6'd0, 16'd0, 16'd0, 16'd0, 16'd0, STATUS_BAD, 1'b1}},
        '{16'd100, 16'd100, 7'd65,  1'b1, '{6'd0, 16'd0, 16'd0, 16'd0, 16'd0, STATUS_BAD, 1'b1}},
        '{16'd1,   16'd1,   7'd127, 1'b1, '{6'd0, 16'd0, 16'd0, 16'd0, 16'd0, STATUS_BAD, 1'b1}},
        '{16'hFFFF, 16'hFFFF, 7'd1, 1'b1, '{6'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, STATUS_OK, 1'b1}},
        '{16'd1,   16'd1,   7'd1,   1'b1, '{6'd0, 16'd0, 16'd1, 16'd0, 16'd1, STATUS_OK, 1'b1}},
        '{16'd0,   16'd0,   7'd12,  1'b0, '0},
        '{16'd120, 16'd0,   7'd6,   1'b0, '0},
        '{16'd120, 16'd80,  7'd12,  1'b0, '0},
        '{16'd97,  16'd89,  7'd12,  1'b0, '0},
        '{16'hFFFF, 16'd1,  7'd64,  1'b0, '0},
        '{16'd64,  16'd64,  7'd64,  1'b0, '0},
        '{16'd7,   16'd3,   7'd60,  1'b0, '0},
        '{16'd100, 16'd30,  7'd7,   1'b0, '0}
    };

    initial begin
        int gap, burst;
        logic [1:0] mode_set[4];
        mode_set = '{MODE_BEST, MODE_REG, MODE_IRR, 2'd3};
        err_cnt = 0;
        tile_cnt = 0;
        req_cnt = 0;
        mdl_mode = MODE_BEST;
        mdl_cut_x = 16'd1;
        mdl_cut_y = 16'd1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        i_start = 1'b0;
        i_area_width = '0;
        i_area_height = '0;
        i_num_tiles = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reset config, then regular-only and irregular passes
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) set_cfg(MODE_REG, 16'd1, 16'd1);
            if (pass == 2) set_cfg(MODE_IRR, 16'hFFFF, 16'd0);
            foreach (dir_tab[i]) begin
                if (pass == 0 || !dir_tab[i].has_exp) begin
                    send_req(dir_tab[i].w, dir_tab[i].h, dir_tab[i].n,
                             dir_tab[i].has_exp, dir_tab[i].exp_tile);
                    idle_gap($urandom_range(0, 3));
                end
            end
            idle_gap(1);
            wait_drain();
        end

        // Random phases over several settings, draining between them
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_cfg(MODE_BEST, 16'd1, 16'd1);
                1: set_cfg(MODE_IRR, 16'd0, 16'hFFFF);
                7: set_cfg(2'd3, 16'hFFFF, 16'hFFFF);
                default: set_cfg(mode_set[$urandom_range(0, 3)], 16'($urandom),
                                 16'($urandom_range(0, 300)));
            endcase
            burst = 0;
            for (int j = 0; j < 14; j++) begin
                send_req(rnd_side(), rnd_side(), rnd_count(), 1'b0, '0);
                if (burst > 0) begin
                    burst--;
                end else begin
                    gap = $urandom_range(1, 40);
                    burst = $urandom_range(0, 5);
                    idle_gap(gap);
                end
                if (j == 6 && ph == 3) begin
                    i_start <= 1'b0;
                    wait_drain();
                end
            end
            idle_gap(1);
            wait_drain();
        end

        $display("covered %0d requests and %0d tiles over all split modes and cutoff extremes",
                 req_cnt, tile_cnt);
        if (err_cnt == 0) begin
            $display("tb_rect_grid_tiler passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("tb_rect_grid_tiler failed");
        end
        $finish;
    end

endmodule
